[sv/gpwc_pkg.sv]
// ----------------------------------------------------------------------------
// gpwc_pkg
// Shared types and constants for the Geiger pulse width counter.
// ----------------------------------------------------------------------------
package gpwc_pkg;

    localparam int GPWC_NUM_BINS = 64;

    localparam int TIME_W  = 32;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 33;
    localparam int BIN_W   = 16;
    localparam int TOTAL_W = 64;
    localparam int THR_W   = 16;
    localparam int DIV_CNT_W = $clog2(TIME_W);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 120;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PILEUP_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REM_THR     = 3'd4;

    // Register reset values.
    localparam logic [THR_W-1:0] NOISE_THR_RST = 16'd10;
    localparam logic [THR_W-1:0] MEDIAN_RST    = 16'd100;
    localparam logic [THR_W-1:0] REM_THR_RST   = 16'd50;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } gpwc_state_t;

    typedef struct packed {
        logic capture;   // take the input item
        logic eval;      // classify the edge, start the divider
        logic div_step;  // one quotient bit
        logic round;     // apply the remainder threshold
        logic update;    // write bin and total, load the result
    } gpwc_cmd_t;

    typedef struct packed {
        logic div_needed;
        logic div_last;
    } gpwc_status_t;

endpackage

[sv/geiger_pulse_width_counter.sv]
// ----------------------------------------------------------------------------
// geiger_pulse_width_counter
// Measures Geiger tube pulse widths from edge events and accumulates counts.
// ----------------------------------------------------------------------------
// Each accepted item passes through ST_EVAL, then, for a kept pulse in pile-up
// mode, ST_DIV (radix-2 divider) and ST_ROUND, then ST_UPDATE; ST_OUT raises m_tvalid.
// One item at a time: a new item is taken the cycle after the result is
// delivered, never while an item is still in work.
// Reset clears all control state, the start time, the total and the bin valid
// bits at once; there is no clearing pass.
module geiger_pulse_width_counter #(
    parameter int NUM_BINS = gpwc_pkg::GPWC_NUM_BINS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gpwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gpwc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gpwc_pkg::S_TDATA_W-1:0]  s_tdata,  // time_us[31:0], bin_index[37:32]
    input  logic                            s_tuser,  // edge_level
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gpwc_pkg::M_TDATA_W-1:0]  m_tdata,  // counts_added[32:0], bin_value[48:33],
                                                      // total_count[112:49]
    output logic                            m_tuser   // pulse_counted
);
    import gpwc_pkg::*;

    gpwc_cmd_t    cmd;
    gpwc_status_t status;

    assign cfg_ready = 1'b1;

    gpwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gpwc_datapath #(
        .NUM_BINS (NUM_BINS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[sv/gpwc_ctrl.sv]
// ----------------------------------------------------------------------------
// gpwc_ctrl
// Sequencer for one edge event: capture, classify, divide and round when needed, update, deliver.
// ----------------------------------------------------------------------------
module gpwc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  gpwc_pkg::gpwc_status_t status,
    output gpwc_pkg::gpwc_cmd_t   cmd
);
    import gpwc_pkg::*;

    gpwc_state_t state_reg;
    gpwc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.div_needed)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/gpwc_datapath.sv]
// ----------------------------------------------------------------------------
// gpwc_datapath
// Configuration registers, pulse width measurement, radix-2 divider,
// bin memory and running total.
// ----------------------------------------------------------------------------
module gpwc_datapath #(
    parameter int NUM_BINS = gpwc_pkg::GPWC_NUM_BINS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [gpwc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gpwc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [gpwc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    input  gpwc_pkg::gpwc_cmd_t                cmd,
    output gpwc_pkg::gpwc_status_t             status,
    output logic [gpwc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser
);
    import gpwc_pkg::*;

    // Only bins reachable by a 6-bit index are ever stored.
    localparam int BIN_DEPTH = (NUM_BINS < (1 << IDX_W)) ? NUM_BINS : (1 << IDX_W);
    localparam int BIN_AW    = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;

    // Configuration.
    logic             enabled_reg;
    logic             pileup_reg;
    logic [THR_W-1:0] noise_thr_reg;
    logic [THR_W-1:0] median_reg;
    logic [THR_W-1:0] rem_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            pileup_reg    <= 1'b0;
            noise_thr_reg <= NOISE_THR_RST;
            median_reg    <= MEDIAN_RST;
            rem_thr_reg   <= REM_THR_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ENABLED:     enabled_reg   <= cfg_data[0];
                CFG_PILEUP_MODE: pileup_reg    <= cfg_data[0];
                CFG_NOISE_THR:   noise_thr_reg <= cfg_data;
                CFG_MEDIAN:      median_reg    <= cfg_data;
                CFG_REM_THR:     rem_thr_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Captured item.
    logic              level_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] width_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              idx_ok_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] in_time;
    logic [IDX_W-1:0]  in_idx;

    assign in_time = s_tdata[TIME_W-1:0];
    assign in_idx  = s_tdata[TIME_W+IDX_W-1:TIME_W];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            level_reg  <= s_tuser;
            time_reg   <= in_time;
            width_reg  <= in_time - start_reg;
            idx_reg    <= in_idx;
            idx_ok_reg <= (32'(in_idx) < NUM_BINS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (cmd.eval && enabled_reg && level_reg)
        begin
            start_reg <= time_reg;
        end
    end

    // A falling edge ending a pulse longer than the noise threshold is kept.
    logic kept;
    logic kept_reg;
    assign kept = enabled_reg && !level_reg && (width_reg > {16'd0, noise_thr_reg});

    assign status.div_needed = kept && pileup_reg;

    // Restoring divider, one quotient bit per cycle.
    logic [THR_W-1:0]     divisor;
    logic [THR_W-1:0]     rem_reg;
    logic [TIME_W-1:0]    quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [THR_W:0]       trial;
    logic                 trial_ge;
    logic [CNT_W-1:0]     counts_reg;

    assign divisor         = (median_reg == '0) ? 16'd1 : median_reg;
    assign trial           = {rem_reg, quo_reg[TIME_W-1]};
    assign trial_ge        = (trial >= {1'b0, divisor});
    assign status.div_last = (div_cnt_reg == DIV_CNT_W'(TIME_W - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            rem_reg     <= '0;
            quo_reg     <= width_reg;
            div_cnt_reg <= '0;
            kept_reg    <= kept;
            counts_reg  <= {{(CNT_W-1){1'b0}}, kept};
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= trial_ge ? THR_W'(trial - {1'b0, divisor}) : trial[THR_W-1:0];
            quo_reg     <= {quo_reg[TIME_W-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        else if (cmd.round)
        begin
            counts_reg <= {1'b0, quo_reg} + {{(CNT_W-1){1'b0}}, (rem_reg >= rem_thr_reg)};
        end
    end

    // Bin memory with registered read; entries not yet written read as zero.
    logic [BIN_W-1:0]     bin_mem [BIN_DEPTH];
    logic [BIN_DEPTH-1:0] bin_vld_reg;
    logic [BIN_W-1:0]     bin_rd_reg;
    logic                 bin_rd_vld_reg;
    logic [BIN_AW-1:0]    bin_addr;
    logic [BIN_W-1:0]     bin_old;
    logic [BIN_W-1:0]     bin_new;
    logic                 bin_wr;

    assign bin_addr = BIN_AW'(idx_reg);
    assign bin_old  = bin_rd_vld_reg ? bin_rd_reg : '0;
    assign bin_new  = bin_old + counts_reg[BIN_W-1:0];
    assign bin_wr   = cmd.update && kept_reg && idx_ok_reg;

    always_ff @(posedge clk)
    begin
        if (bin_wr)
        begin
            bin_mem[bin_addr] <= bin_new;
        end
        bin_rd_reg <= bin_mem[bin_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg    <= '0;
            bin_rd_vld_reg <= 1'b0;
        end
        else
        begin
            bin_rd_vld_reg <= bin_vld_reg[bin_addr];
            if (bin_wr)
            begin
                bin_vld_reg[bin_addr] <= 1'b1;
            end
        end
    end

    // Running total.
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;

    assign total_next = total_reg + {{(TOTAL_W-CNT_W){1'b0}}, counts_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (cmd.update)
        begin
            total_reg <= total_next;
        end
    end

    // Result register.
    logic               out_counted_reg;
    logic [CNT_W-1:0]   out_added_reg;
    logic [BIN_W-1:0]   out_bin_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_counted_reg <= kept_reg;
            out_added_reg   <= counts_reg;
            out_bin_reg     <= idx_ok_reg ? bin_new : '0;
            out_total_reg   <= total_next;
        end
    end

    assign m_tuser = out_counted_reg;
    assign m_tdata = {{(M_TDATA_W-CNT_W-BIN_W-TOTAL_W){1'b0}},
                      out_total_reg, out_bin_reg, out_added_reg};

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the Geiger pulse width counter. A queue of edge items
// feeds a bursty driver, the receiver stalls on its own pattern, and every
// accepted item is run through a local model of the counter whose expected
// result is compared field by field with what comes out of the block.
// ----------------------------------------------------------------------------
module tb_top;
    import gpwc_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 500;

    typedef struct packed {
        logic             edge_level;
        logic [TIME_W-1:0] time_us;
        logic [IDX_W-1:0]  bin_index;
    } edge_item_t;

    typedef struct packed {
        logic               pulse_counted;
        logic [CNT_W-1:0]   counts_added;
        logic [BIN_W-1:0]   bin_value;
        logic [TOTAL_W-1:0] total_count;
    } count_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    geiger_pulse_width_counter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    edge_item_t    edges_to_send[$];
    count_result_t expected_counts[$];
    int            error_count = 0;
    int            idle_cycles = 0;

    // Model state, updated at the handshakes seen on the ports.
    logic              cfg_en     = 1'b0;
    logic              cfg_pileup = 1'b0;
    logic [THR_W-1:0]  cfg_noise  = NOISE_THR_RST;
    logic [THR_W-1:0]  cfg_median = MEDIAN_RST;
    logic [THR_W-1:0]  cfg_rem    = REM_THR_RST;
    logic [TIME_W-1:0] pulse_start_us = '0;
    logic [TOTAL_W-1:0] tally_total = '0;
    logic [BIN_W-1:0]  bin_tally[GPWC_NUM_BINS];

    // Settings last written, used to aim the generated pulse widths.
    logic [THR_W-1:0]  gen_noise  = NOISE_THR_RST;
    logic [THR_W-1:0]  gen_median = MEDIAN_RST;
    logic [THR_W-1:0]  gen_rem    = REM_THR_RST;
    logic [TIME_W-1:0] gen_now    = '0;

    initial
    begin
        foreach (bin_tally[i])
            bin_tally[i] = '0;
    end

    function automatic count_result_t count_edge(edge_item_t ev);
        count_result_t     r;
        logic [TIME_W-1:0] pulse_w;
        logic [TIME_W-1:0] divisor;
        logic [CNT_W-1:0]  n;
        r = '0;
        if (cfg_en)
        begin
            if (ev.edge_level)
                pulse_start_us = ev.time_us;
            else
            begin
                pulse_w = ev.time_us - pulse_start_us;
                if (pulse_w > {16'd0, cfg_noise})
                begin
                    r.pulse_counted = 1'b1;
                    if (!cfg_pileup)
                        n = CNT_W'(1);
                    else
                    begin
                        // A median of zero divides by one.
                        divisor = (cfg_median == '0) ? 32'd1 : {16'd0, cfg_median};
                        n = {1'b0, pulse_w / divisor};
                        if ((pulse_w % divisor) >= {16'd0, cfg_rem})
                            n = n + CNT_W'(1);
                    end
                    r.counts_added = n;
                    if (32'(ev.bin_index) < GPWC_NUM_BINS)
                        bin_tally[ev.bin_index] = bin_tally[ev.bin_index] + n[BIN_W-1:0];
                    tally_total = tally_total + {{(TOTAL_W-CNT_W){1'b0}}, n};
                end
            end
        end
        r.bin_value   = (32'(ev.bin_index) < GPWC_NUM_BINS) ? bin_tally[ev.bin_index] : '0;
        r.total_count = tally_total;
        return r;
    endfunction

    // Prediction and register shadowing at the input handshakes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENABLED:     cfg_en     = cfg_data[0];
                    CFG_PILEUP_MODE: cfg_pileup = cfg_data[0];
                    CFG_NOISE_THR:   cfg_noise  = cfg_data;
                    CFG_MEDIAN:      cfg_median = cfg_data;
                    CFG_REM_THR:     cfg_rem    = cfg_data;
                    default:         ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_counts.push_back(count_edge('{s_tuser, s_tdata[31:0],
                                                       s_tdata[37:32]}));
        end
    end

    // Driver: bursts of items with random gaps in between.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        edge_item_t ev;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (edges_to_send.size() > 0)
            begin
                ev = edges_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= ev.edge_level;
                s_tdata  <= {2'b00, ev.bin_index, ev.time_us};
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                else
                begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: stalls on one of four patterns, chosen anew at random as rx_cycle advances.
    int rx_cycle = 0;
    int rx_mode = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rx_cycle = rx_cycle + 1;
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (rx_cycle % 7 == 0);
                default: m_tready <= (rx_cycle % 16) >= 10;
            endcase
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        count_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_counts.size() == 0)
            begin
                $display("%0t: result with nothing expected: tuser %0b tdata %h",
                         $realtime, m_tuser, m_tdata);
                error_count = error_count + 1;
            end
            else
            begin
                want = expected_counts.pop_front();
                if (m_tuser !== want.pulse_counted)
                begin
                    $display("%0t: pulse_counted expected %0b actual %0b",
                             $realtime, want.pulse_counted, m_tuser);
                    error_count = error_count + 1;
                end
                if (m_tdata[32:0] !== want.counts_added)
                begin
                    $display("%0t: counts_added expected %0d actual %0d",
                             $realtime, want.counts_added, m_tdata[32:0]);
                    error_count = error_count + 1;
                end
                if (m_tdata[48:33] !== want.bin_value)
                begin
                    $display("%0t: bin_value expected %0d actual %0d",
                             $realtime, want.bin_value, m_tdata[48:33]);
                    error_count = error_count + 1;
                end
                if (m_tdata[112:49] !== want.total_count)
                begin
                    $display("%0t: total_count expected %0d actual %0d",
                             $realtime, want.total_count, m_tdata[112:49]);
                    error_count = error_count + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic push_edge(input logic level, input logic [TIME_W-1:0] t,
                             input logic [IDX_W-1:0] idx);
        edges_to_send.push_back('{level, t, idx});
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (edges_to_send.size() != 0 || s_tvalid || expected_counts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic en, input logic pile,
                                  input logic [THR_W-1:0] noise,
                                  input logic [THR_W-1:0] median,
                                  input logic [THR_W-1:0] rem);
        wait_drained();
        write_reg(CFG_ENABLED, {15'd0, en});
        write_reg(CFG_PILEUP_MODE, {15'd0, pile});
        write_reg(CFG_NOISE_THR, noise);
        write_reg(CFG_MEDIAN, median);
        write_reg(CFG_REM_THR, rem);
        gen_noise  = noise;
        gen_median = median;
        gen_rem    = rem;
    endtask

    // Widths aimed at the noise threshold, at the remainder threshold and
    // around multiples of the median, plus wide and fully random ones.
    function automatic logic [TIME_W-1:0] pick_width();
        logic [TIME_W-1:0] m;
        logic [TIME_W-1:0] w;
        m = (gen_median == '0) ? 32'd1 : {16'd0, gen_median};
        case ($urandom_range(0, 5))
            0:       w = {16'd0, gen_noise} + $urandom_range(0, 2) - 1;
            1:       w = m * $urandom_range(0, 4) + {16'd0, gen_rem} + $urandom_range(0, 2) - 1;
            2:       w = m * $urandom_range(1, 8) + $urandom_range(0, m - 1);
            3:       w = $urandom();
            4:       w = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: w = $urandom_range(0, 300);
        endcase
        return w;
    endfunction

    function automatic logic [IDX_W-1:0] pick_bin();
        // Favor a few bins so that their 16-bit values wrap.
        return ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 3))
                                           : IDX_W'($urandom_range(0, 63));
    endfunction

    // Pushes about n items: mostly rising/falling pairs, the rest lone edges.
    task automatic random_items(input int n);
        int                pushed;
        logic [IDX_W-1:0]  idx;
        pushed = 0;
        while (pushed < n)
        begin
            idx = pick_bin();
            if ($urandom_range(0, 7) == 0)
                gen_now = $urandom();
            case ($urandom_range(0, 19))
                0, 1:
                begin
                    push_edge(1'b0, gen_now + pick_width(), idx);
                    pushed = pushed + 1;
                end
                2, 3:
                begin
                    push_edge(1'b1, gen_now, idx);
                    pushed = pushed + 1;
                end
                4:
                begin
                    push_edge(1'($urandom_range(0, 1)), $urandom(),
                              IDX_W'($urandom_range(0, 63)));
                    pushed = pushed + 1;
                end
                default:
                begin
                    push_edge(1'b1, gen_now, idx);
                    gen_now = gen_now + pick_width();
                    push_edge(1'b0, gen_now, idx);
                    pushed = pushed + 2;
                end
            endcase
            gen_now = gen_now + $urandom_range(1, 5000);
        end
    endtask

    initial
    begin
        int counted;
        int chunk;
        logic [THR_W-1:0] noise;
        logic [THR_W-1:0] median;
        logic [THR_W-1:0] rem;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Out of reset the block is disabled and ignores edges.
        push_edge(1'b1, 32'hFFFF_FFFF, 6'd63);
        push_edge(1'b0, 32'd0, 6'd0);

        // Single-tube mode: a width equal to the threshold is noise.
        apply_settings(1'b1, 1'b0, 16'd10, 16'd100, 16'd50);
        push_edge(1'b1, 32'd0, 6'd0);
        push_edge(1'b0, 32'd10, 6'd1);
        push_edge(1'b1, 32'd100, 6'd2);
        push_edge(1'b0, 32'd111, 6'd63);
        push_edge(1'b0, 32'hFFFF_FFFF, 6'd63);

        // Median of one: the widest wrapped pulse gives the largest count.
        apply_settings(1'b1, 1'b1, 16'd0, 16'd1, 16'd0);
        push_edge(1'b1, 32'd5, 6'd5);
        push_edge(1'b0, 32'd4, 6'd5);
        push_edge(1'b1, 32'd7, 6'd6);
        push_edge(1'b0, 32'd7, 6'd6);
        push_edge(1'b0, 32'd8, 6'd6);

        // A median of zero acts as one.
        apply_settings(1'b1, 1'b1, 16'd0, 16'd0, 16'hFFFF);
        push_edge(1'b1, 32'd0, 6'd7);
        push_edge(1'b0, 32'd1000, 6'd7);

        apply_settings(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_edge(1'b1, 32'd0, 6'd8);
        push_edge(1'b0, 32'd65535, 6'd8);
        push_edge(1'b0, 32'd65536, 6'd8);
        push_edge(1'b1, 32'd0, 6'd9);
        push_edge(1'b0, 32'hFFFF_FFFF, 6'd9);

        // A kept pulse shorter than the median adds zero counts.
        apply_settings(1'b1, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF);
        push_edge(1'b1, 32'd0, 6'd10);
        push_edge(1'b0, 32'd5, 6'd10);

        // Disabled again: the rising edge must not move the start time.
        apply_settings(1'b0, 1'b0, 16'd10, 16'd100, 16'd50);
        push_edge(1'b1, 32'd123, 6'd11);
        push_edge(1'b0, 32'd500, 6'd11);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0:       noise = 16'd0;
                1:       noise = THR_W'($urandom_range(1, 40));
                2:       noise = 16'hFFFF;
                default: noise = THR_W'($urandom());
            endcase
            case ($urandom_range(0, 4))
                0:       median = THR_W'($urandom_range(0, 1));
                1:       median = THR_W'($urandom_range(2, 200));
                2:       median = 16'hFFFF;
                default: median = THR_W'($urandom());
            endcase
            case ($urandom_range(0, 3))
                0:       rem = 16'd0;
                1:       rem = 16'hFFFF;
                2:       rem = THR_W'($urandom_range(0, median));
                default: rem = THR_W'($urandom());
            endcase
            if ($urandom_range(0, 7) == 0)
            begin
                apply_settings(1'b0, 1'($urandom_range(0, 1)), noise, median, rem);
                random_items(16);
            end
            else
            begin
                apply_settings(1'b1, 1'($urandom_range(0, 1)), noise, median, rem);
                chunk = $urandom_range(40, 80);
                random_items(chunk);
                counted = counted + chunk;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_counts.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $realtime, expected_counts.size());
            error_count = error_count + 1;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
sv/gpwc_pkg.sv
sv/gpwc_ctrl.sv
sv/gpwc_datapath.sv
sv/geiger_pulse_width_counter.sv
dv/tb_top.sv
